[hw/rtl/exl_pkg.sv]
// shared types, codes and lookup tables of the expression lexer
`default_nettype none

package exl_pkg;

	localparam int POS_BITS_DEFAULT = 16;
	localparam int FIELD_BITS = 16;
	localparam int KIND_BITS = 5;
	localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

	// scan modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_MINUS = 2'd1;
	localparam logic [1:0] MODE_INT   = 2'd2;
	localparam logic [1:0] MODE_FRAC  = 2'd3;

	// token kinds
	localparam logic [KIND_BITS-1:0] KIND_PLUS     = 5'd0;
	localparam logic [KIND_BITS-1:0] KIND_STAR     = 5'd1;
	localparam logic [KIND_BITS-1:0] KIND_SEMI     = 5'd2;
	localparam logic [KIND_BITS-1:0] KIND_BAR      = 5'd3;
	localparam logic [KIND_BITS-1:0] KIND_TILDE    = 5'd4;
	localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 5'd5;
	localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 5'd6;
	localparam logic [KIND_BITS-1:0] KIND_PERCENT  = 5'd7;
	localparam logic [KIND_BITS-1:0] KIND_EQUAL    = 5'd8;
	localparam logic [KIND_BITS-1:0] KIND_DOLLAR   = 5'd9;
	localparam logic [KIND_BITS-1:0] KIND_AMP      = 5'd10;
	localparam logic [KIND_BITS-1:0] KIND_AT       = 5'd11;
	localparam logic [KIND_BITS-1:0] KIND_BANG     = 5'd12;
	localparam logic [KIND_BITS-1:0] KIND_QUEST    = 5'd13;
	localparam logic [KIND_BITS-1:0] KIND_LBRACK   = 5'd14;
	localparam logic [KIND_BITS-1:0] KIND_RBRACK   = 5'd15;
	localparam logic [KIND_BITS-1:0] KIND_ARROW    = 5'd16;
	localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 5'd17;
	localparam logic [KIND_BITS-1:0] KIND_MINUS    = 5'd18;
	localparam logic [KIND_BITS-1:0] KIND_KW_F     = 5'd19;
	localparam logic [KIND_BITS-1:0] KIND_KW_B     = 5'd20;
	localparam logic [KIND_BITS-1:0] KIND_KW_H     = 5'd21;
	localparam logic [KIND_BITS-1:0] KIND_KW_S     = 5'd22;
	localparam logic [KIND_BITS-1:0] KIND_KW_V     = 5'd23;
	localparam logic [KIND_BITS-1:0] KIND_KW_A     = 5'd24;
	localparam logic [KIND_BITS-1:0] KIND_VARIABLE = 5'd25;
	localparam logic [KIND_BITS-1:0] KIND_ERROR    = 5'd26;
	localparam logic [KIND_BITS-1:0] KIND_EOF      = 5'd27;

	// characters
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_GT      = 8'h3e;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;

	// result queue
	localparam int SLOTS = 3;
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [FIELD_BITS-1:0] line;
		logic [FIELD_BITS-1:0] column;
		logic [FIELD_BITS-1:0] length;
		logic [7:0]            symbol;
		logic                  end_of_run;
	} tok_t;

	typedef struct packed {
		logic [SLOTS-1:0] valid;
		tok_t [SLOTS-1:0] tok;
	} slots_t;

	typedef struct packed {
		logic                 hit;
		logic [KIND_BITS-1:0] kind;
	} lookup_t;

	// single-character operators
	function automatic lookup_t op_lookup(input logic [7:0] c);
		lookup_t r;
		r.hit = 1'b1;
		case (c)
			8'h2b: r.kind = KIND_PLUS;
			8'h2a: r.kind = KIND_STAR;
			8'h3b: r.kind = KIND_SEMI;
			8'h7c: r.kind = KIND_BAR;
			8'h7e: r.kind = KIND_TILDE;
			8'h28: r.kind = KIND_LPAREN;
			8'h29: r.kind = KIND_RPAREN;
			8'h25: r.kind = KIND_PERCENT;
			8'h3d: r.kind = KIND_EQUAL;
			8'h24: r.kind = KIND_DOLLAR;
			8'h26: r.kind = KIND_AMP;
			8'h40: r.kind = KIND_AT;
			8'h21: r.kind = KIND_BANG;
			8'h3f: r.kind = KIND_QUEST;
			8'h5b: r.kind = KIND_LBRACK;
			8'h5d: r.kind = KIND_RBRACK;
			default: begin
				r.hit = 1'b0;
				r.kind = KIND_ERROR;
			end
		endcase
		return r;
	endfunction

	// upper-case keywords
	function automatic lookup_t kw_lookup(input logic [7:0] c);
		lookup_t r;
		r.hit = 1'b1;
		case (c)
			8'h46: r.kind = KIND_KW_F;
			8'h42: r.kind = KIND_KW_B;
			8'h48: r.kind = KIND_KW_H;
			8'h53: r.kind = KIND_KW_S;
			8'h56: r.kind = KIND_KW_V;
			8'h41: r.kind = KIND_KW_A;
			default: begin
				r.hit = 1'b0;
				r.kind = KIND_ERROR;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/exl_char_if.sv]
// character input channel
`default_nettype none

interface exl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       has_char;
	logic       last;

	modport source(output valid, output ch, output has_char, output last, input ready);
	modport sink(input valid, input ch, input has_char, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/exl_tok_if.sv]
// token output channel
`default_nettype none

interface exl_tok_if;
	logic                               valid;
	logic                               ready;
	logic [exl_pkg::KIND_BITS-1:0]      kind;
	logic [exl_pkg::FIELD_BITS-1:0]     tok_row;
	logic [exl_pkg::FIELD_BITS-1:0]     tok_column;
	logic [exl_pkg::FIELD_BITS-1:0]     tok_length;
	logic [7:0]                         symbol;
	logic                               end_of_run;

	modport source(output valid, output kind, output tok_row, output tok_column,
		output tok_length, output symbol, output end_of_run, input ready);
	modport sink(input valid, input kind, input tok_row, input tok_column,
		input tok_length, input symbol, input end_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/exl_scan.sv]
// scanner state and per-character token decision
`default_nettype none

module exl_scan #(
	parameter int POS_BITS = exl_pkg::POS_BITS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    ch,
	input  wire logic          has_char,
	input  wire logic          last,
	output exl_pkg::slots_t    slots
);

	typedef logic [POS_BITS-1:0] pos_t;

	localparam int WIDE = (POS_BITS > exl_pkg::FIELD_BITS) ? POS_BITS : exl_pkg::FIELD_BITS;

	logic [1:0] mode_q, mode_c;
	pos_t line_q, col_q, sline_q, scol_q, len_q;
	pos_t line_c, col_c, sline_c, scol_c, len_c;

	function automatic pos_t sat_inc(input pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	function automatic logic [exl_pkg::FIELD_BITS-1:0] clamp(input pos_t v);
		logic [WIDE-1:0] w;
		w = WIDE'(v);
		if (w > WIDE'(exl_pkg::FIELD_MAX))
			return exl_pkg::FIELD_MAX;
		return w[exl_pkg::FIELD_BITS-1:0];
	endfunction

	function automatic exl_pkg::tok_t make_tok(input logic [exl_pkg::KIND_BITS-1:0] k,
		input pos_t l, input pos_t c, input pos_t n, input logic [7:0] s);
		exl_pkg::tok_t t;
		t.kind = k;
		t.line = clamp(l);
		t.column = clamp(c);
		t.length = clamp(n);
		t.symbol = s;
		t.end_of_run = 1'b0;
		return t;
	endfunction

	logic is_digit, is_dot, is_space, is_lower;
	exl_pkg::lookup_t op_hit, kw_hit;
	logic taken;
	logic pre_v, chr_v, mid_v, eof_v;
	exl_pkg::tok_t pre_t, chr_t, mid_t, eof_t;

	assign is_digit = ch inside {[exl_pkg::CH_ZERO:exl_pkg::CH_NINE]};
	assign is_dot   = (ch == exl_pkg::CH_DOT);
	assign is_space = (ch == exl_pkg::CH_SPACE) || (ch inside {[exl_pkg::CH_TAB:exl_pkg::CH_CR]});
	assign is_lower = ch inside {[exl_pkg::CH_LOWER_A:exl_pkg::CH_LOWER_Z]};
	assign op_hit   = exl_pkg::op_lookup(ch);
	assign kw_hit   = exl_pkg::kw_lookup(ch);

	always_comb begin
		mode_c = mode_q;
		line_c = line_q;
		col_c = col_q;
		sline_c = sline_q;
		scol_c = scol_q;
		len_c = len_q;
		taken = 1'b0;
		pre_v = 1'b0;
		chr_v = 1'b0;
		pre_t = make_tok(exl_pkg::KIND_ARROW, sline_q, scol_q, pos_t'(2), exl_pkg::CH_NUL);
		chr_t = make_tok(exl_pkg::KIND_ERROR, line_q, col_q, '0, ch);
		if (has_char) begin
			// continue an open token
			case (mode_q)
				exl_pkg::MODE_MINUS: begin
					if (ch == exl_pkg::CH_GT) begin
						pre_v = 1'b1;
						mode_c = exl_pkg::MODE_IDLE;
						len_c = '0;
						taken = 1'b1;
					end else if (is_digit) begin
						len_c = sat_inc(len_q);
						mode_c = exl_pkg::MODE_INT;
						taken = 1'b1;
					end
				end
				exl_pkg::MODE_INT: begin
					if (is_digit || is_dot) begin
						len_c = sat_inc(len_q);
						if (is_dot)
							mode_c = exl_pkg::MODE_FRAC;
						taken = 1'b1;
					end
				end
				exl_pkg::MODE_FRAC: begin
					if (is_digit) begin
						len_c = sat_inc(len_q);
						taken = 1'b1;
					end
				end
				default: ;
			endcase
			if (!taken) begin
				// flush what was open, then treat the character fresh
				if (mode_q == exl_pkg::MODE_MINUS) begin
					pre_v = 1'b1;
					pre_t = make_tok(exl_pkg::KIND_MINUS, sline_q, scol_q, pos_t'(1),
						exl_pkg::CH_MINUS);
				end else if (mode_q != exl_pkg::MODE_IDLE) begin
					pre_v = 1'b1;
					pre_t = make_tok(exl_pkg::KIND_NUMBER, sline_q, scol_q, len_q,
						exl_pkg::CH_NUL);
				end
				mode_c = exl_pkg::MODE_IDLE;
				len_c = '0;
				if (is_space) begin
					chr_v = 1'b0;
				end else if (op_hit.hit) begin
					chr_v = 1'b1;
					chr_t = make_tok(op_hit.kind, line_q, col_q, pos_t'(1), ch);
				end else if (kw_hit.hit) begin
					chr_v = 1'b1;
					chr_t = make_tok(kw_hit.kind, line_q, col_q, pos_t'(1), ch);
				end else if (ch == exl_pkg::CH_MINUS || is_digit) begin
					sline_c = line_q;
					scol_c = col_q;
					len_c = pos_t'(1);
					mode_c = is_digit ? exl_pkg::MODE_INT : exl_pkg::MODE_MINUS;
				end else if (is_lower) begin
					chr_v = 1'b1;
					chr_t = make_tok(exl_pkg::KIND_VARIABLE, line_q, col_q, pos_t'(1), ch);
				end else begin
					chr_v = 1'b1;
				end
			end
			// advance position
			if (ch == exl_pkg::CH_NEWLINE) begin
				line_c = sat_inc(line_q);
				col_c = '0;
			end else begin
				col_c = sat_inc(col_q);
			end
		end
	end

	// middle slot: token of the character, or the flush forced by end of input
	always_comb begin
		mid_v = 1'b0;
		mid_t = chr_t;
		if (chr_v) begin
			mid_v = 1'b1;
		end else if (last && mode_c == exl_pkg::MODE_MINUS) begin
			mid_v = 1'b1;
			mid_t = make_tok(exl_pkg::KIND_MINUS, sline_c, scol_c, pos_t'(1), exl_pkg::CH_MINUS);
		end else if (last && mode_c != exl_pkg::MODE_IDLE) begin
			mid_v = 1'b1;
			mid_t = make_tok(exl_pkg::KIND_NUMBER, sline_c, scol_c, len_c, exl_pkg::CH_NUL);
		end
		eof_v = last;
		eof_t = make_tok(exl_pkg::KIND_EOF, line_c, col_c, '0, exl_pkg::CH_NUL);
	end

	always_comb begin
		slots.valid = {eof_v, mid_v, pre_v};
		slots.tok[0] = pre_t;
		slots.tok[1] = mid_t;
		slots.tok[2] = eof_t;
		slots.tok[2].end_of_run = eof_v;
		slots.tok[1].end_of_run = mid_v && !eof_v;
		slots.tok[0].end_of_run = pre_v && !mid_v && !eof_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= exl_pkg::MODE_IDLE;
			line_q <= '0;
			col_q <= '0;
			sline_q <= '0;
			scol_q <= '0;
			len_q <= '0;
		end else if (step) begin
			if (last) begin
				mode_q <= exl_pkg::MODE_IDLE;
				line_q <= '0;
				col_q <= '0;
				sline_q <= '0;
				scol_q <= '0;
				len_q <= '0;
			end else begin
				mode_q <= mode_c;
				line_q <= line_c;
				col_q <= col_c;
				sline_q <= sline_c;
				scol_q <= scol_c;
				len_q <= len_c;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/exl_tok_queue.sv]
// small token queue taking up to three tokens a cycle, one out a cycle while the sink is ready
`default_nettype none

module exl_tok_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  exl_pkg::slots_t   slots,
	output logic              room,
	exl_tok_if.source         tokens
);

	exl_pkg::tok_t entry_q [exl_pkg::QDEPTH];
	logic [exl_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [exl_pkg::QCNT_BITS-1:0] count_q;
	logic [exl_pkg::QPTR_BITS-1:0] off [exl_pkg::SLOTS];
	logic [exl_pkg::QPTR_BITS-1:0] push_n;
	logic pop;
	exl_pkg::tok_t head;

	// packed offsets of the valid slots
	assign off[0] = '0;
	assign off[1] = exl_pkg::QPTR_BITS'(slots.valid[0]);
	assign off[2] = exl_pkg::QPTR_BITS'(slots.valid[0]) + exl_pkg::QPTR_BITS'(slots.valid[1]);
	assign push_n = push ? exl_pkg::QPTR_BITS'($countones(slots.valid)) : '0;

	assign room = (count_q <= exl_pkg::QCNT_BITS'(exl_pkg::QDEPTH - exl_pkg::SLOTS));
	assign pop = tokens.valid && tokens.ready;

	assign head = entry_q[rd_ptr_q];
	assign tokens.valid = (count_q != '0);
	assign tokens.kind = head.kind;
	assign tokens.tok_row = head.line;
	assign tokens.tok_column = head.column;
	assign tokens.tok_length = head.length;
	assign tokens.symbol = head.symbol;
	assign tokens.end_of_run = head.end_of_run;

	always_ff @(posedge clk) begin
		for (int i = 0; i < exl_pkg::QDEPTH; i++) begin
			for (int k = 0; k < exl_pkg::SLOTS; k++) begin
				if (push && slots.valid[k] &&
					(wr_ptr_q + off[k]) == exl_pkg::QPTR_BITS'(i))
					entry_q[i] <= slots.tok[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop)
				rd_ptr_q <= rd_ptr_q + exl_pkg::QPTR_BITS'(1);
			count_q <= count_q + exl_pkg::QCNT_BITS'(push_n)
				- exl_pkg::QCNT_BITS'(pop);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/expression_lexer_core.sv]
// expression lexer top level: input register, scanner and token queue
// first token of a character is offered after the input register and the token queue
// throughput: one character per cycle unless stalled; an item's tokens leave one at a time
// input stalls only when the four-entry token queue has fewer than three free entries
// reset: arst_n clears scan state to line 0, column 0 and empties both stages
`default_nettype none

module expression_lexer_core #(
	parameter int POS_BITS = exl_pkg::POS_BITS_DEFAULT
) (
	input wire logic   clk,
	input wire logic   arst_n,
	exl_char_if.sink   chars,
	exl_tok_if.source  tokens
);

	// input register stage
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       has_char_s1;
	logic       last_s1;

	logic            room;
	logic            step;
	logic            accept;
	exl_pkg::slots_t slots;

	// the held character is scanned once the queue can take its worst case
	assign step = valid_s1 && room;
	// the input register refills in the same cycle it drains
	assign chars.ready = !valid_s1 || step;
	assign accept = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= chars.ch;
			has_char_s1 <= chars.has_char;
			last_s1 <= chars.last;
		end
	end

	// scanner: line/column tracking, open minus or number, up to three tokens
	exl_scan #(
		.POS_BITS(POS_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.ch       (ch_s1),
		.has_char (has_char_s1),
		.last     (last_s1),
		.slots    (slots)
	);

	// token queue decouples the scanner from output backpressure
	exl_tok_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.slots  (slots),
		.room   (room),
		.tokens (tokens)
	);

endmodule

`default_nettype wire
